// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the record parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge while out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds while out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/ihex_pkg.sv =====
// Types and constants shared by the record parser modules.
package ihex_pkg;

	localparam logic [7:0] CHAR_COLON       = 8'h3a;
	localparam logic [7:0] SIG_HI           = 8'hc0;
	localparam logic [7:0] SIG_LO           = 8'hde;
	localparam logic [7:0] TYPE_EXT_LINEAR  = 8'h04;
	localparam logic [7:0] TYPE_BLOCK_START = 8'h0a;

	localparam logic [1:0] ST_FAIL    = 2'd0;
	localparam logic [1:0] ST_OK      = 2'd1;
	localparam logic [1:0] ST_BAD_SIG = 2'd2;

	// Event passed from the character front end to the record back end.
	typedef struct packed {
		logic       eol;
		logic       has_byte;
		logic [7:0] value;
	} ihex_evt_t;

	// Output word, last field in the lowest bits.
	typedef struct packed {
		logic [5:0]  pad;
		logic [1:0]  status;
		logic [15:0] section_number;
		logic [31:0] full_address;
		logic [7:0]  record_type;
		logic [15:0] record_offset;
		logic [7:0]  record_count;
		logic [7:0]  byte_index;
		logic [7:0]  data_byte;
	} ihex_out_t;

endpackage

// ===== rtl/ihex_front.sv =====
// Character front end: finds the colon, pairs hex digits into bytes.
`include "assert_macros.svh"

module ihex_front #(
	parameter int MAX_RECORD_BYTES = 261
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          char_in,
	input  logic                end_of_line,
	input  logic                q_full,
	output logic                push,
	output ihex_pkg::ihex_evt_t evt
);
	import ihex_pkg::*;

	localparam int CW = $clog2(MAX_RECORD_BYTES + 1);

	typedef enum logic [1:0] {SEEK, READ, HOLD} phase_t;

	phase_t        phase_q;
	logic [3:0]    hi_q;
	logic          pend_q;
	logic [CW-1:0] cnt_q;

	logic       is_hex;
	logic [3:0] dig;
	logic       accept;
	logic       byte_done;

	always_comb begin
		is_hex = 1'b1;
		dig    = 4'd0;
		if (char_in >= 8'h30 && char_in <= 8'h39) begin
			dig = 4'(char_in - 8'h30);
		end else if (char_in >= 8'h41 && char_in <= 8'h46) begin
			dig = 4'(char_in - 8'h37);
		end else if (char_in >= 8'h61 && char_in <= 8'h66) begin
			dig = 4'(char_in - 8'h57);
		end else begin
			is_hex = 1'b0;
		end
	end

	assign in_ready     = !q_full;
	assign accept       = in_valid && in_ready;
	assign byte_done    = (phase_q == READ) && is_hex && pend_q;
	assign evt.eol      = end_of_line;
	assign evt.has_byte = byte_done;
	assign evt.value    = {hi_q, dig};
	assign push         = accept && (byte_done || end_of_line);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= SEEK;
			hi_q    <= 4'd0;
			pend_q  <= 1'b0;
			cnt_q   <= '0;
		end else if (accept) begin
			if (end_of_line) begin
				// line ends: start over for the next record
				phase_q <= SEEK;
				hi_q    <= 4'd0;
				pend_q  <= 1'b0;
				cnt_q   <= '0;
			end else begin
				case (phase_q)
					SEEK: begin
						if (char_in == CHAR_COLON) begin
							phase_q <= READ;
						end else if (char_in == 8'h00) begin
							phase_q <= HOLD;
						end
					end
					READ: begin
						if (!is_hex) begin
							phase_q <= HOLD;
							pend_q  <= 1'b0;
						end else if (!pend_q) begin
							hi_q   <= dig;
							pend_q <= 1'b1;
						end else begin
							pend_q <= 1'b0;
							cnt_q  <= cnt_q + CW'(1);
							if (cnt_q == CW'(MAX_RECORD_BYTES - 1)) begin
								phase_q <= HOLD;
							end
						end
					end
					default: phase_q <= HOLD;
				endcase
			end
		end
	end

	`ASSERT_CLK(a_pend_only_reading, (phase_q != READ) |-> !pend_q, "nibble pending outside read")
	`ASSERT_CLK(a_limit_holds, (cnt_q == CW'(MAX_RECORD_BYTES)) |-> (phase_q != READ), "byte limit passed")
	`ASSERT_NEVER(a_push_full, push && q_full, "push into full queue")

endmodule

// ===== rtl/ihex_fifo.sv =====
// Two-entry queue between the front end and the back end.
`include "assert_macros.svh"

module ihex_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ihex_pkg::ihex_evt_t wr_evt,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output ihex_pkg::ihex_evt_t rd_evt
);
	import ihex_pkg::*;

	ihex_evt_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_evt  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	`ASSERT_NEVER(a_count_range, count_q == 2'd3, "queue count beyond depth")
	`ASSERT_CLK(a_ptr_track, (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q),
		"pointers disagree with count")

endmodule

// ===== rtl/ihex_back.sv =====
// Record back end: checksum, header capture, payload and summary words.
`include "assert_macros.svh"

module ihex_back #(
	parameter int MAX_RECORD_BYTES = 261
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  ihex_pkg::ihex_evt_t evt,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_kind,
	output ihex_pkg::ihex_out_t out_word
);
	import ihex_pkg::*;

	localparam int CW = $clog2(MAX_RECORD_BYTES + 1);
	localparam int IW = (CW > 8) ? CW : 8;

	logic [CW-1:0] cnt_q;
	logic [7:0]    sum_q;
	logic [7:0]    hdr_q  [4];
	logic [7:0]    lead_q [4];
	logic [31:0]   base_q;
	logic [15:0]   sec_q;
	logic          valid_q;
	logic          kind_q;
	ihex_out_t     word_q;

	logic [7:0]    hdr_n  [4];
	logic [7:0]    lead_n [4];
	logic [7:0]    sum_n;
	logic [31:0]   base_n;
	logic [15:0]   sec_n;
	logic [1:0]    st_n;
	logic [15:0]   off_n;
	logic [IW-1:0] idx;
	logic          payload;
	ihex_out_t     word_n;

	assign pop = !empty && (!valid_q || out_ready);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			hdr_n[i]  = hdr_q[i];
			lead_n[i] = lead_q[i];
		end
		if (evt.has_byte && cnt_q < CW'(4)) begin
			hdr_n[cnt_q[1:0]] = evt.value;
		end else if (evt.has_byte && cnt_q < CW'(8)) begin
			lead_n[cnt_q[1:0]] = evt.value;
		end
		sum_n   = sum_q + (evt.has_byte ? evt.value : 8'd0);
		idx     = IW'(cnt_q) - IW'(4);
		payload = evt.has_byte && (cnt_q >= CW'(4)) && (idx < IW'(hdr_q[0]));
		off_n   = {hdr_n[1], hdr_n[2]};
		base_n  = base_q;
		sec_n   = sec_q;
		st_n    = ST_FAIL;
		if ((evt.has_byte || cnt_q != '0) && sum_n == 8'd0) begin
			st_n = ST_OK;
			if (hdr_n[3] == TYPE_EXT_LINEAR) begin
				base_n = {lead_n[0], lead_n[1], 16'h0000};
			end else if (hdr_n[3] == TYPE_BLOCK_START) begin
				if (lead_n[2] == SIG_HI && lead_n[3] == SIG_LO) begin
					sec_n = {lead_n[0], lead_n[1]};
				end else begin
					st_n = ST_BAD_SIG;
				end
			end
		end
		word_n = '0;
		if (evt.eol) begin
			word_n.record_count   = hdr_n[0];
			word_n.record_offset  = off_n;
			word_n.record_type    = hdr_n[3];
			word_n.full_address   = base_n + {16'h0000, off_n};
			word_n.section_number = sec_n;
			word_n.status         = st_n;
		end else begin
			word_n.data_byte  = evt.value;
			word_n.byte_index = idx[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_q   <= 8'd0;
			base_q  <= 32'd0;
			sec_q   <= 16'd0;
			valid_q <= 1'b0;
			kind_q  <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				hdr_q[i]  <= 8'd0;
				lead_q[i] <= 8'd0;
			end
		end else begin
			if (pop) begin
				valid_q <= evt.eol || payload;
				kind_q  <= evt.eol;
				if (evt.eol) begin
					// record closed: keep address state, clear the rest
					cnt_q  <= '0;
					sum_q  <= 8'd0;
					base_q <= base_n;
					sec_q  <= sec_n;
					for (int i = 0; i < 4; i++) begin
						hdr_q[i]  <= 8'd0;
						lead_q[i] <= 8'd0;
					end
				end else begin
					if (evt.has_byte) cnt_q <= cnt_q + CW'(1);
					sum_q <= sum_n;
					for (int i = 0; i < 4; i++) begin
						hdr_q[i]  <= hdr_n[i];
						lead_q[i] <= lead_n[i];
					end
				end
			end else if (valid_q && out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= word_n;
		end
	end

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_word  = word_q;

	`ASSERT_NEVER(a_status_code, valid_q && kind_q && word_q.status != ST_FAIL &&
		word_q.status != ST_OK && word_q.status != ST_BAD_SIG, "summary with unknown status")
	`ASSERT_CLK(a_pay_in_count, (valid_q && !kind_q) |-> (word_q.byte_index < hdr_q[0]),
		"payload index beyond record count")
	`ASSERT_CLK(a_eol_clears, (pop && evt.eol) |=> (cnt_q == '0 && sum_q == 8'd0),
		"record state not cleared after line end")

endmodule

// ===== rtl/intel_hex_record_parser_unit.sv =====
// Top level of the Intel HEX record parser: front end, queue, back end.
//
//  Channel  Dir  Handshake              Contents
//  s_axis   in   s_axis_tvalid/tready   tdata: char_in; tlast: end_of_line
//  m_axis   out  m_axis_tvalid/tready   tdata: record fields; tuser: kind
//
// One character is taken per cycle while the queue is not full; the front end
// writes the queue on the accepting edge, and the back end loads the output
// register from the queue once that register is free.
// The back end's record update and address add sit in one stage, which sets
// the rate at one word a cycle while m_axis is ready.
// Reset clears all parse, checksum and address state at once; no sweep.
// A stalled m_axis fills the two-entry queue, after which s_axis_tready drops.
module intel_hex_record_parser_unit #(
	parameter int MAX_RECORD_BYTES = 261
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // [7:0] char_in
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [7:0] data_byte, [15:8] byte_index, [23:16] record_count,
	// [39:24] record_offset, [47:40] record_type, [79:48] full_address,
	// [95:80] section_number, [97:96] status, [103:98] zero
	output logic [103:0] m_axis_tdata,
	output logic         m_axis_tuser   // [0] kind
);
	import ihex_pkg::*;

	ihex_evt_t push_evt;
	ihex_evt_t pop_evt;
	ihex_out_t word;
	logic      push;
	logic      pop;
	logic      q_full;
	logic      q_empty;

	ihex_front #(
		.MAX_RECORD_BYTES(MAX_RECORD_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.char_in    (s_axis_tdata),
		.end_of_line(s_axis_tlast),
		.q_full     (q_full),
		.push       (push),
		.evt        (push_evt)
	);

	ihex_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_evt(push_evt),
		.full  (q_full),
		.pop   (pop),
		.empty (q_empty),
		.rd_evt(pop_evt)
	);

	ihex_back #(
		.MAX_RECORD_BYTES(MAX_RECORD_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.evt      (pop_evt),
		.pop      (pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_kind (m_axis_tuser),
		.out_word (word)
	);

	assign m_axis_tdata = word;

endmodule
